@@ hdl/mpta_pkg.sv @@
// shared types and constants for the masked pixel tone adjust block
`default_nettype none
package mpta_pkg;

	localparam int LANES  = 3;
	localparam int NUM_W  = 30;
	localparam int DEN_W  = 18;
	localparam int GW_W   = 25;
	localparam int STEPS  = 8;

	localparam logic [2:0] MODE_BRIGHT   = 3'd0;
	localparam logic [2:0] MODE_SAT      = 3'd1;
	localparam logic [2:0] MODE_HIGH     = 3'd2;
	localparam logic [2:0] MODE_SHADOW   = 3'd3;
	localparam logic [2:0] MODE_WB       = 3'd4;
	localparam logic [2:0] MODE_CONTRAST = 3'd5;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_GAIN = 1'b1;

	// 255^2 * 4, denominator of (v - 0.5)^2 in the tone curves
	localparam logic [DEN_W-1:0] TONE_DEN = 18'd260100;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [8:0] mask_weight;
	} pix_word_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} res_word_t;

	typedef struct packed {
		logic             dir;
		logic             sat;
		logic [7:0]       dval;
		logic [7:0]       q;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} lane_t;

	typedef struct packed {
		logic                   valid;
		logic signed [GW_W-1:0] gw;
		lane_t [LANES-1:0]      lane;
	} div_in_t;

	typedef struct packed {
		logic                   valid;
		logic signed [GW_W-1:0] gw;
		logic [LANES-1:0][7:0]  pix;
	} div_out_t;

endpackage
`default_nettype wire

@@ hdl/mpta_div.sv @@
// pipelined saturating divider, one quotient bit per stage, three lanes
`default_nettype none
module mpta_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  mpta_pkg::div_in_t  din,
	output mpta_pkg::div_out_t dout
);
	import mpta_pkg::*;

	div_in_t          stg_s [STEPS];
	div_in_t          src   [STEPS];
	div_in_t          nxt   [STEPS];
	logic [NUM_W-1:0] trial [STEPS][LANES];
	div_in_t          last;

	always_comb begin
		src[0] = din;
		for (int s = 1; s < STEPS; s++) begin
			src[s] = stg_s[s-1];
		end
		for (int s = 0; s < STEPS; s++) begin
			nxt[s] = src[s];
			for (int l = 0; l < LANES; l++) begin
				trial[s][l] = NUM_W'(src[s].lane[l].den) << (STEPS - 1 - s);
				if (s == 0) begin
					nxt[s].lane[l].sat = src[s].lane[l].num >=
						(NUM_W'(src[s].lane[l].den) << STEPS);
				end
				if (src[s].lane[l].num >= trial[s][l]) begin
					nxt[s].lane[l].num = src[s].lane[l].num - trial[s][l];
					nxt[s].lane[l].q   = {src[s].lane[l].q[6:0], 1'b1};
				end else begin
					nxt[s].lane[l].q   = {src[s].lane[l].q[6:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < STEPS; s++) begin
				stg_s[s] <= '0;
			end
		end else if (en) begin
			for (int s = 0; s < STEPS; s++) begin
				stg_s[s] <= nxt[s];
			end
		end
	end

	always_comb begin
		last       = stg_s[STEPS-1];
		dout.valid = last.valid;
		dout.gw    = last.gw;
		for (int l = 0; l < LANES; l++) begin
			if (last.lane[l].dir) begin
				dout.pix[l] = last.lane[l].dval;
			end else if (last.lane[l].sat) begin
				dout.pix[l] = 8'd255;
			end else begin
				dout.pix[l] = last.lane[l].q;
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/masked_pixel_tone_adjust_core.sv @@
// top level of the masked pixel tone adjust pipeline
// throughput: one word per cycle while no result word is stalled, set by the fully pipelined dividers
//   (one quotient bit per stage, two passes of eight stages)
// a stalled result freezes the whole pipeline, nothing is dropped or repeated
// reset clears all valid bits and sets mode and gain to zero
`default_nettype none
module masked_pixel_tone_adjust_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	output logic                pix_stall,
	input  mpta_pkg::pix_word_t pix,
	output logic                res_valid,
	input  logic                res_stall,
	output mpta_pkg::res_word_t res,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data
);
	import mpta_pkg::*;

	localparam logic signed [25:0] ONE_K = 26'sd1048576;

	function automatic logic [7:0] max3(input logic [LANES-1:0][7:0] c);
		logic [7:0] m;
		m = c[0];
		if (c[1] > m) m = c[1];
		if (c[2] > m) m = c[2];
		return m;
	endfunction

	function automatic logic [7:0] min3(input logic [LANES-1:0][7:0] c);
		logic [7:0] m;
		m = c[0];
		if (c[1] < m) m = c[1];
		if (c[2] < m) m = c[2];
		return m;
	endfunction

	// |2*max - 255|, distance of the value from mid grey
	function automatic logic [7:0] tone_t(input logic [7:0] mx);
		logic [8:0] two;
		two = {mx, 1'b0};
		if (mx[7]) return 8'(two - 9'd255);
		return 8'(9'd255 - two);
	endfunction

	// truncate a q.20 value to an integer and clamp to 0..255
	function automatic logic [7:0] sat8(input logic signed [35:0] x);
		logic signed [35:0] sh;
		sh = x >>> 20;
		if (x <= 0) return 8'd0;
		if (sh > 36'sd255) return 8'd255;
		return sh[7:0];
	endfunction

	// tone numerator, already divided by 2^20, zero when not positive
	function automatic logic [NUM_W-1:0] tone_num(input logic [7:0] c,
		input logic signed [41:0] gwtt, input logic up);
		logic signed [51:0] delta;
		logic signed [51:0] base;
		logic signed [51:0] sum;
		logic signed [51:0] sh;
		delta = $signed({1'b0, c}) * gwtt;
		base  = $signed((52'(c) * 52'(TONE_DEN)) << 20);
		sum   = up ? base + delta : base - delta;
		sh    = sum >>> 20;
		if (sum <= 0) return '0;
		return sh[NUM_W-1:0];
	endfunction

	// configuration registers
	logic [2:0]         mode_q;
	logic signed [15:0] gain_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BRIGHT;
			gain_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE: mode_q <= cfg_data[2:0];
				REG_GAIN: gain_q <= $signed(cfg_data);
				default:  mode_q <= mode_q;
			endcase
		end
	end

	// global advance: the pipeline moves unless a result word is held
	logic en;
	assign en        = !(res_valid && res_stall);
	assign pix_stall = !en;

	// stage 1: capture the pixel word
	logic                  v_s1;
	logic [LANES-1:0][7:0] c_s1;
	logic [8:0]            m_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= pix_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1[0] <= pix.red_in;
			c_s1[1] <= pix.green_in;
			c_s1[2] <= pix.blue_in;
			m_s1    <= pix.mask_weight;
		end
	end

	// stage 2: gain times mask, max/min, squared tone distance
	logic signed [25:0] gwp;
	logic [7:0]         mx1;
	logic [7:0]         t1;

	assign gwp = gain_q * $signed({1'b0, m_s1});
	assign mx1 = max3(c_s1);
	assign t1  = tone_t(mx1);

	logic                   v_s2;
	logic [LANES-1:0][7:0]  c_s2;
	logic signed [GW_W-1:0] gw_s2;
	logic [7:0]             mx_s2;
	logic [7:0]             mn_s2;
	logic [15:0]            tt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2  <= c_s1;
			gw_s2 <= $signed(gwp[GW_W-1:0]);
			mx_s2 <= mx1;
			mn_s2 <= min3(c_s1);
			tt_s2 <= 16'(t1) * 16'(t1);
		end
	end

	// stage 3: products with the scale factor k = 1 + gain*w
	logic signed [25:0] k2;
	logic [7:0]         d2;

	assign k2 = ONE_K + 26'(gw_s2);
	assign d2 = mx_s2 - mn_s2;

	logic                   v_s3;
	logic [LANES-1:0][7:0]  c_s3;
	logic [7:0]             mx_s3;
	logic [7:0]             mn_s3;
	logic signed [GW_W-1:0] gw_s3;
	logic                   kpos_s3;
	logic signed [34:0]     ck_s3  [LANES];
	logic signed [34:0]     cmk_s3 [LANES];
	logic [15:0]            nsat_s3 [LANES];
	logic signed [34:0]     mxk_s3;
	logic signed [34:0]     kd_s3;
	logic signed [34:0]     bw_s3;
	logic signed [41:0]     gwtt_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s3    <= c_s2;
			mx_s3   <= mx_s2;
			mn_s3   <= mn_s2;
			gw_s3   <= gw_s2;
			kpos_s3 <= k2 > 26'sd0;
			mxk_s3  <= k2 * $signed({1'b0, mx_s2});
			kd_s3   <= k2 * $signed({1'b0, d2});
			bw_s3   <= $signed({1'b0, c_s2[2]}) * (ONE_K - 26'(gw_s2));
			gwtt_s3 <= gw_s2 * $signed({1'b0, tt_s2});
			for (int l = 0; l < LANES; l++) begin
				ck_s3[l]   <= k2 * $signed({1'b0, c_s2[l]});
				cmk_s3[l]  <= k2 * $signed({1'b0, 8'(mx_s2 - c_s2[l])});
				nsat_s3[l] <= 16'(mx_s2) * 16'(c_s2[l] - mn_s2);
			end
		end
	end

	// stage 4: per-mode choice of a direct value or a numerator/denominator
	div_in_t dina_n;
	div_in_t dina_s4;
	logic    tone_on;

	always_comb begin
		dina_n.valid = v_s3;
		dina_n.gw    = gw_s3;
		tone_on      = 1'b0;
		for (int l = 0; l < LANES; l++) begin
			dina_n.lane[l].dir  = 1'b1;
			dina_n.lane[l].sat  = 1'b0;
			dina_n.lane[l].dval = c_s3[l];
			dina_n.lane[l].q    = '0;
			dina_n.lane[l].num  = '0;
			dina_n.lane[l].den  = DEN_W'(1);
		end
		case (mode_q)
			MODE_BRIGHT: begin
				for (int l = 0; l < LANES; l++) begin
					if (!kpos_s3 || mx_s3 == 8'd0) begin
						// black pixel or non-positive k gives black
						dina_n.lane[l].dval = 8'd0;
					end else if (mxk_s3 >= $signed({7'b0, 8'd255, 20'b0})) begin
						// scale limited so that max lands on 255
						dina_n.lane[l].dir = 1'b0;
						dina_n.lane[l].num = NUM_W'({c_s3[l], 8'b0} - 16'(c_s3[l]));
						dina_n.lane[l].den = DEN_W'(mx_s3);
					end else begin
						dina_n.lane[l].dval = ck_s3[l][27:20];
					end
				end
			end
			MODE_SAT: begin
				// grey pixel passes unchanged
				if (mx_s3 != mn_s3) begin
					for (int l = 0; l < LANES; l++) begin
						if (kd_s3 >= $signed({7'b0, mx_s3, 20'b0})) begin
							dina_n.lane[l].dir = 1'b0;
							dina_n.lane[l].num = NUM_W'(nsat_s3[l]);
							dina_n.lane[l].den = DEN_W'(mx_s3 - mn_s3);
						end else begin
							dina_n.lane[l].dval =
								sat8($signed({8'b0, mx_s3, 20'b0}) - 36'(cmk_s3[l]));
						end
					end
				end
			end
			MODE_HIGH: tone_on = mx_s3[7];
			MODE_SHADOW: tone_on = !mx_s3[7];
			MODE_CONTRAST: tone_on = mx_s3[7];
			MODE_WB: begin
				dina_n.lane[0].dval = sat8(36'(ck_s3[0]));
				dina_n.lane[2].dval = sat8(36'(bw_s3));
			end
			default: tone_on = 1'b0;
		endcase
		if (tone_on) begin
			for (int l = 0; l < LANES; l++) begin
				dina_n.lane[l].dir = 1'b0;
				dina_n.lane[l].num = tone_num(c_s3[l], gwtt_s3, mx_s3[7]);
				dina_n.lane[l].den = TONE_DEN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dina_s4 <= '0;
		else if (en) dina_s4 <= dina_n;
	end

	// first divider pass, stages 5 to 12
	div_out_t ra;

	mpta_div u_div_a (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    (dina_s4),
		.dout   (ra)
	);

	// second pass: shadow side of contrast on the saturated highlight result
	logic [7:0] mxb;

	assign mxb = max3(ra.pix);

	logic                   v_s13;
	logic [LANES-1:0][7:0]  pix_s13;
	logic signed [GW_W-1:0] gw_s13;
	logic [15:0]            tt_s13;
	logic [7:0]             mx_s13;
	logic                   app_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s13 <= 1'b0;
		else if (en) v_s13 <= ra.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s13 <= ra.pix;
			gw_s13  <= ra.gw;
			tt_s13  <= 16'(tone_t(mxb)) * 16'(tone_t(mxb));
			mx_s13  <= mxb;
			app_s13 <= (mode_q == MODE_CONTRAST) && !mxb[7];
		end
	end

	logic                  v_s14;
	logic [LANES-1:0][7:0] pix_s14;
	logic signed [41:0]    gwtt_s14;
	logic                  up_s14;
	logic                  app_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s14 <= 1'b0;
		else if (en) v_s14 <= v_s13;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s14  <= pix_s13;
			gwtt_s14 <= gw_s13 * $signed({1'b0, tt_s13});
			up_s14   <= mx_s13[7];
			app_s14  <= app_s13;
		end
	end

	div_in_t dinb_n;
	div_in_t dinb_s15;

	always_comb begin
		dinb_n.valid = v_s14;
		dinb_n.gw    = '0;
		for (int l = 0; l < LANES; l++) begin
			dinb_n.lane[l].sat  = 1'b0;
			dinb_n.lane[l].q    = '0;
			dinb_n.lane[l].dval = pix_s14[l];
			if (app_s14) begin
				dinb_n.lane[l].dir = 1'b0;
				dinb_n.lane[l].num = tone_num(pix_s14[l], gwtt_s14, up_s14);
				dinb_n.lane[l].den = TONE_DEN;
			end else begin
				dinb_n.lane[l].dir = 1'b1;
				dinb_n.lane[l].num = '0;
				dinb_n.lane[l].den = DEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dinb_s15 <= '0;
		else if (en) dinb_s15 <= dinb_n;
	end

	// second divider pass, stages 16 to 23
	div_out_t rb;

	mpta_div u_div_b (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    (dinb_s15),
		.dout   (rb)
	);

	// output register, holds while the result word is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid <= 1'b0;
		else if (en) res_valid <= rb.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.red_out   <= rb.pix[0];
			res.green_out <= rb.pix[1];
			res.blue_out  <= rb.pix[2];
		end
	end

endmodule
`default_nettype wire

@@ sim/masked_pixel_tone_adjust_core_tb.sv @@
// self-checking testbench for the masked pixel tone adjust core
`timescale 1ns / 1ps
`default_nettype none
module masked_pixel_tone_adjust_core_tb;
	import mpta_pkg::*;

	localparam int RUN_ITEMS = 750;
	localparam int LATENCY = 24;

	logic clk;
	logic arst_n;
	logic pix_valid;
	logic pix_stall;
	pix_word_t pix;
	logic res_valid;
	logic res_stall;
	res_word_t res;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [15:0] cfg_data;

	masked_pixel_tone_adjust_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow copy of the block's registers
	logic [2:0] cur_mode;
	logic signed [15:0] cur_gain;

	res_word_t pending_pixels[$];
	int errors;
	bit hold_res;      // long receiver hold-off request
	bit sender_done;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// ---------------- predictor ----------------
	function automatic longint clamp_div(longint n, longint d);
		longint q;
		if (n <= 0) return 0;
		q = n / d;
		return (q > 255) ? 255 : q;
	endfunction

	// one side of the tone curve, up selects the highlight side
	function automatic void tone_curve(ref longint c[3], input longint gw, input bit up);
		longint mx, t, dlt, n, den;
		den = 64'd1048576 * 64'd260100;
		mx = c[0];
		if (c[1] > mx) mx = c[1];
		if (c[2] > mx) mx = c[2];
		if (up) begin
			if (2 * mx <= 255) return;
			t = 2 * mx - 255;
		end else begin
			if (2 * mx >= 255) return;
			t = 255 - 2 * mx;
		end
		for (int i = 0; i < 3; i++) begin
			dlt = c[i] * gw * t * t;
			n = c[i] * den + (up ? dlt : -dlt);
			c[i] = clamp_div(n, den);
		end
	endfunction

	function automatic res_word_t adjust_pixel(pix_word_t p, logic [2:0] md,
			logic signed [15:0] g);
		longint c[3];
		longint one, m, gw, k, mx, mn, d;
		res_word_t r;
		one = 64'd1048576;
		m = p.mask_weight;
		gw = longint'(g) * m;
		k = one + gw;
		c[0] = p.red_in;
		c[1] = p.green_in;
		c[2] = p.blue_in;
		mx = c[0]; mn = c[0];
		for (int i = 1; i < 3; i++) begin
			if (c[i] > mx) mx = c[i];
			if (c[i] < mn) mn = c[i];
		end
		case (md)
			MODE_BRIGHT: begin
				for (int i = 0; i < 3; i++) begin
					if (k <= 0 || mx == 0) c[i] = 0;
					else if (mx * k >= 255 * one) c[i] = (c[i] * 255) / mx;
					else c[i] = clamp_div(c[i] * k, one);
				end
			end
			MODE_SAT: begin
				d = mx - mn;
				if (d != 0) begin
					for (int i = 0; i < 3; i++) begin
						if (k * d >= mx * one) c[i] = (mx * (c[i] - mn)) / d;
						else c[i] = clamp_div(mx * one - (mx - c[i]) * k, one);
					end
				end
			end
			MODE_HIGH: tone_curve(c, gw, 1'b1);
			MODE_SHADOW: tone_curve(c, gw, 1'b0);
			MODE_WB: begin
				c[0] = clamp_div(c[0] * k, one);
				c[2] = clamp_div(c[2] * (one - gw), one);
			end
			MODE_CONTRAST: begin
				tone_curve(c, gw, 1'b1);
				tone_curve(c, gw, 1'b0);
			end
			default: ;
		endcase
		r.red_out = c[0][7:0];
		r.green_out = c[1][7:0];
		r.blue_out = c[2][7:0];
		return r;
	endfunction

	// ---------------- helpers ----------------
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic write_reg(logic idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_MODE) cur_mode = val[2:0];
		else cur_gain = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop offering pixel words
	task automatic idle_pixels();
		@(negedge clk);
		pix_valid <= 1'b0;
	endtask

	// wait until every result is back and the pipeline has drained
	task automatic drain_pipe();
		idle_pixels();
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// offer one word and hold it until accepted, valid stays up for a following word
	task automatic send_pixel(pix_word_t p, bit use_gaps);
		int g;
		g = use_gaps ? gap_len() : 0;
		if (g > 0) begin
			idle_pixels();
			repeat (g - 1) @(negedge clk);
		end
		@(negedge clk);
		pix_valid <= 1'b1;
		pix <= p;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
		pending_pixels.push_back(adjust_pixel(p, cur_mode, cur_gain));
	endtask

	function automatic pix_word_t rand_pixel(bit extreme);
		pix_word_t p;
		p.red_in = 8'($urandom);
		p.green_in = 8'($urandom);
		p.blue_in = 8'($urandom);
		p.mask_weight = 9'($urandom);
		if (extreme && $urandom_range(0, 3) == 0) p.red_in = $urandom_range(0, 1) ? 8'hff : 8'h00;
		if (extreme && $urandom_range(0, 3) == 0) p.green_in = p.red_in;
		if (extreme && $urandom_range(0, 3) == 0) p.blue_in = p.red_in;
		if ($urandom_range(0, 3) == 0) p.mask_weight = 9'd256;
		else if ($urandom_range(0, 5) == 0) p.mask_weight = $urandom_range(0, 1) ? 9'd0 : 9'd511;
		return p;
	endfunction

	// ---------------- result checking ----------------
	always @(posedge clk) begin
		res_word_t exp_r;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t unexpected result word %h", $time, res);
				errors++;
			end else begin
				exp_r = pending_pixels.pop_front();
				if (res.red_out !== exp_r.red_out)
					$display("%0t red mismatch exp %0d got %0d", $time, exp_r.red_out, res.red_out);
				if (res.green_out !== exp_r.green_out)
					$display("%0t green mismatch exp %0d got %0d", $time,
						exp_r.green_out, res.green_out);
				if (res.blue_out !== exp_r.blue_out)
					$display("%0t blue mismatch exp %0d got %0d", $time, exp_r.blue_out, res.blue_out);
				if (res !== exp_r) errors++;
			end
		end
	end

	// receiver stall: random gaps, plus the long hold-off when requested
	initial begin
		int g;
		res_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_res) begin
				res_stall <= 1'b1;
				repeat (200) @(negedge clk);
				hold_res = 1'b0;
			end
			g = ($urandom_range(0, 4) == 0) ? gap_len() : 0;
			if (g > 0) begin
				res_stall <= 1'b1;
				repeat (g - 1) @(negedge clk);
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// ---------------- directed table ----------------
	typedef struct {
		bit         is_cfg;
		logic       idx;
		logic [15:0] val;
		pix_word_t  p;
		bit         has_exp;
		res_word_t  e;
	} dir_row_t;

	dir_row_t dir_rows[$];

	function automatic void add_cfg(logic idx, logic [15:0] val);
		dir_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1; r.idx = idx; r.val = val;
		dir_rows.push_back(r);
	endfunction

	function automatic void add_pix(logic [7:0] rr, logic [7:0] gg, logic [7:0] bb,
			logic [8:0] m, bit he, res_word_t e);
		dir_row_t r;
		r = '{default: '0};
		r.p = '{rr, gg, bb, m};
		r.has_exp = he; r.e = e;
		dir_rows.push_back(r);
	endfunction

	initial begin
		int n_sent;
		errors = 0;
		hold_res = 1'b0;
		sender_done = 1'b0;
		cur_mode = MODE_BRIGHT;
		cur_gain = '0;
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// after reset: brightness with zero gain passes the pixel
		add_pix(8'd10, 8'd200, 8'd255, 9'd256, 1, '{8'd10, 8'd200, 8'd255});
		add_pix(8'd0, 8'd0, 8'd0, 9'd511, 1, '{8'd0, 8'd0, 8'd0});
		add_cfg(REG_GAIN, 16'h7fff);
		add_pix(8'd0, 8'd0, 8'd0, 9'd256, 1, '{8'd0, 8'd0, 8'd0});   // black stays black
		add_pix(8'd100, 8'd50, 8'd20, 9'd256, 0, '0);
		add_pix(8'd255, 8'd255, 8'd255, 9'd511, 1, '{8'd255, 8'd255, 8'd255});
		add_cfg(REG_GAIN, 16'h8000);
		add_pix(8'd100, 8'd50, 8'd20, 9'd256, 1, '{8'd0, 8'd0, 8'd0}); // k below zero
		add_cfg(REG_MODE, {13'd0, MODE_SAT});
		add_pix(8'd77, 8'd77, 8'd77, 9'd256, 1, '{8'd77, 8'd77, 8'd77}); // grey passes
		add_pix(8'd200, 8'd100, 8'd10, 9'd256, 0, '0);                   // negative k
		add_cfg(REG_GAIN, 16'h7fff);
		add_pix(8'd200, 8'd100, 8'd10, 9'd511, 0, '0);
		add_cfg(REG_MODE, {13'd0, MODE_HIGH});
		add_pix(8'd250, 8'd200, 8'd30, 9'd256, 0, '0);
		add_pix(8'd100, 8'd20, 8'd0, 9'd256, 1, '{8'd100, 8'd20, 8'd0}); // dark side untouched
		add_cfg(REG_MODE, {13'd0, MODE_SHADOW});
		add_pix(8'd100, 8'd20, 8'd0, 9'd256, 0, '0);
		add_cfg(REG_MODE, {13'd0, MODE_WB});
		add_pix(8'd128, 8'd128, 8'd128, 9'd256, 0, '0);
		add_cfg(REG_MODE, {13'd0, MODE_CONTRAST});
		add_pix(8'd255, 8'd10, 8'd128, 9'd300, 0, '0);
		add_pix(8'd60, 8'd10, 8'd30, 9'd511, 0, '0);
		add_cfg(REG_MODE, 16'd6);                                        // unused code passes
		add_pix(8'd1, 8'd2, 8'd3, 9'd256, 1, '{8'd1, 8'd2, 8'd3});
		add_cfg(REG_MODE, 16'd7);
		add_pix(8'd255, 8'd0, 8'd170, 9'd511, 1, '{8'd255, 8'd0, 8'd170});

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				drain_pipe();
				write_reg(dir_rows[i].idx, dir_rows[i].val);
			end else begin
				send_pixel(dir_rows[i].p, 1'b0);
				if (dir_rows[i].has_exp && pending_pixels[$] !== dir_rows[i].e) begin
					$display("%0t table row %0d: predictor %h, table %h", $time, i,
						pending_pixels[$], dir_rows[i].e);
					errors++;
				end
			end
		end

		// random phases, each under its own register setting
		n_sent = 0;
		for (int ph = 0; n_sent < RUN_ITEMS; ph++) begin
			logic [15:0] gsel;
			drain_pipe();
			case (ph % 5)
				0: gsel = 16'h7fff;
				1: gsel = 16'h8000;
				2: gsel = 16'h0000;
				default: gsel = (ph % 2) ? 16'($urandom_range(0, 8191)) - 16'd4096 : 16'($urandom);
			endcase
			write_reg(REG_MODE, 16'($urandom_range(0, 7)));
			write_reg(REG_GAIN, gsel);
			if (ph == 2) hold_res = 1'b1;   // receiver backs up the pipeline
			for (int j = 0; j < 60 && n_sent < RUN_ITEMS; j++) begin
				send_pixel(rand_pixel(1'b1), (ph % 4) != 1);
				n_sent++;
				if (ph == 3 && j == 30) begin
					// sender waits for every result before going on
					idle_pixels();
					while (pending_pixels.size() != 0) @(posedge clk);
				end
			end
		end

		begin
			int waitc;
			waitc = 0;
			idle_pixels();
			while (pending_pixels.size() != 0 && waitc < 100000) begin
				@(posedge clk);
				waitc++;
			end
			repeat (LATENCY + 8) @(posedge clk);
		end
		if (errors == 0 && pending_pixels.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

@@ sim.f @@
hdl/mpta_pkg.sv
hdl/mpta_div.sv
hdl/masked_pixel_tone_adjust_core.sv
sim/masked_pixel_tone_adjust_core_tb.sv
